// File: rtl/core/dqa_pkg.sv
// shared types and constants of the array double-ended queue
// no dependencies
package dqa_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned WordW = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DISPLAY    = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } stat_e;

endpackage

// File: rtl/core/array_double_ended_queue.sv
// top level of the array double-ended queue
// depends on dqa_pkg and dqa_ram
//
// usage
//   input channel: command_i and value_i, a request is taken on a rising edge
//   with in_valid_i high and in_stall_o low
//   output channel: status_o, data_o and last_o, a request is taken on a
//   rising edge with out_valid_o high and out_stall_i low
//   push commands are answered from the output register in the cycle after they
//   are taken; the next command can be taken in the very next cycle
//   pop commands read the slot memory, their answer goes through the memory
//   read register into the output register; the input stalls until it is loaded
//   display reads one stored word per cycle while the output does not stall,
//   through the single memory read port, and the input stays stalled until
//   the word marked last is loaded
//   commands 5 to 7 are taken and dropped without any answer
//   a stall on the output freezes the output register and, through it, the
//   whole block; the memory read data is held while a word waits
//   reset clears the indices and marks the queue empty; the slot memory is
//   not cleared and needs no clearing pass
module array_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dqa_pkg::CmdW-1:0]            command_i,
  input  logic signed [dqa_pkg::WordW-1:0]    value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dqa_pkg::StatW-1:0]           status_o,
  output logic signed [dqa_pkg::WordW-1:0]    data_o,
  output logic                                last_o
);

  import dqa_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1; // memory read outstanding

  logic            state_q, state_d;
  logic [IdxW-1:0] front_q, front_d;
  logic [IdxW-1:0] rear_q, rear_d;
  logic            empty_q, empty_d;
  logic [IdxW-1:0] addr_q, addr_d;  // slot being read
  logic            disp_q, disp_d;  // current read belongs to a display

  // output register
  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] status_q, status_d;
  logic [WordW-1:0] data_q, data_d;
  logic             last_q, last_d;
  logic             out_load;

  // memory ports
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic             re;
  logic [IdxW-1:0]  raddr;
  logic [WordW-1:0] rdata;

  logic out_free;
  logic accept;
  logic read_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign read_last  = !disp_q || (addr_q == rear_q);

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    rear_d   = rear_q;
    empty_d  = empty_q;
    addr_d   = addr_q;
    disp_d   = disp_q;
    out_load = 1'b0;
    status_d = status_q;
    data_d   = data_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = '0;
    re       = 1'b0;
    raddr    = addr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_load = 1'b1;
              last_d   = 1'b1;
              if (empty_q) begin
                // first word always lands in slot 0
                we       = 1'b1;
                waddr    = '0;
                front_d  = '0;
                rear_d   = '0;
                empty_d  = 1'b0;
                status_d = STAT_OK;
                data_d   = value_i;
              end else if (cmd_e'(command_i) == CMD_PUSH_FRONT) begin
                if (front_q != '0) begin
                  we       = 1'b1;
                  waddr    = front_q - 1'b1;
                  front_d  = front_q - 1'b1;
                  status_d = STAT_OK;
                  data_d   = value_i;
                end else begin
                  status_d = STAT_OVERFLOW;
                  data_d   = '0;
                end
              end else begin
                if (rear_q != LastIdx) begin
                  we       = 1'b1;
                  waddr    = rear_q + 1'b1;
                  rear_d   = rear_q + 1'b1;
                  status_d = STAT_OK;
                  data_d   = value_i;
                end else begin
                  status_d = STAT_OVERFLOW;
                  data_d   = '0;
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_DISPLAY: begin
              if (empty_q) begin
                out_load = 1'b1;
                status_d = STAT_EMPTY;
                data_d   = '0;
                last_d   = 1'b1;
              end else begin
                re      = 1'b1;
                state_d = S_READ;
                disp_d  = (cmd_e'(command_i) == CMD_DISPLAY);
                raddr   = (cmd_e'(command_i) == CMD_POP_BACK) ? rear_q : front_q;
                addr_d  = raddr;
                if (cmd_e'(command_i) != CMD_DISPLAY) begin
                  if (front_q == rear_q) begin
                    // last word removed
                    empty_d = 1'b1;
                    front_d = '0;
                    rear_d  = '0;
                  end else if (cmd_e'(command_i) == CMD_POP_FRONT) begin
                    front_d = front_q + 1'b1;
                  end else begin
                    rear_d = rear_q - 1'b1;
                  end
                end
              end
            end
            default: begin
              // unknown command, dropped
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          status_d = STAT_OK;
          data_d   = rdata;
          last_d   = read_last;
          if (read_last) begin
            state_d = S_IDLE;
          end else begin
            // fetch the next display word while this one is loaded
            re     = 1'b1;
            raddr  = addr_q + 1'b1;
            addr_d = addr_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  dqa_ram #(
    .Width (WordW),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      empty_q     <= 1'b1;
      addr_q      <= '0;
      disp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= empty_d;
      addr_q      <= addr_d;
      disp_q      <= disp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload of the output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = data_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/dqa_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
module dqa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: bench/testbench.sv
// self-checking bench for the array double-ended queue
// needs dqa_pkg and the array_double_ended_queue rtl
`timescale 1ns / 1ps

module testbench;
  import dqa_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 230;

  // one pending command for the driver
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic signed [WordW-1:0] val;
  } deque_cmd_t;

  // one answer the queue should give back
  typedef struct packed {
    stat_e status;
    logic signed [WordW-1:0] data;
    logic last;
  } deque_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CmdW-1:0] command_i = '0;
  logic signed [WordW-1:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [StatW-1:0] status_o;
  logic signed [WordW-1:0] data_o;
  logic last_o;

  deque_cmd_t command_q[$];
  deque_reply_t reply_q[$];
  int unsigned fault_count = 0;
  int unsigned counted_cmds = 0;

  // shadow copy of the queue contents
  logic signed [WordW-1:0] slot_mem [DEPTH];
  int unsigned front_idx = 0;
  int unsigned rear_idx = 0;
  bit deque_empty = 1'b1;

  // sender burst shaping
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_seg = 0;

  int unsigned quiet_cycles = 0;

  array_double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .data_o     (data_o),
    .last_o     (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void expect_reply(stat_e status, logic signed [WordW-1:0] data,
                                       logic last);
    deque_reply_t r;
    r.status = status;
    r.data = data;
    r.last = last;
    reply_q.push_back(r);
  endfunction

  // an empty queue takes its first word in slot 0 from either end
  function automatic void load_first(logic signed [WordW-1:0] word);
    front_idx = 0;
    rear_idx = 0;
    slot_mem[0] = word;
    deque_empty = 1'b0;
  endfunction

  // works out the answers of one accepted command and updates the shadow state
  function automatic void predict_deque(logic [CmdW-1:0] cmd, logic signed [WordW-1:0] word);
    logic signed [WordW-1:0] got;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (deque_empty) begin
          load_first(word);
          expect_reply(STAT_OK, word, 1'b1);
        end else if (front_idx != 0) begin
          front_idx--;
          slot_mem[front_idx] = word;
          expect_reply(STAT_OK, word, 1'b1);
        end else begin
          // front pinned at slot 0, refused even with room at the back
          expect_reply(STAT_OVERFLOW, '0, 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (deque_empty) begin
          load_first(word);
          expect_reply(STAT_OK, word, 1'b1);
        end else if (rear_idx >= DEPTH - 1) begin
          expect_reply(STAT_OVERFLOW, '0, 1'b1);
        end else begin
          rear_idx++;
          slot_mem[rear_idx] = word;
          expect_reply(STAT_OK, word, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_empty) begin
          expect_reply(STAT_EMPTY, '0, 1'b1);
        end else begin
          got = (cmd == CMD_POP_FRONT) ? slot_mem[front_idx] : slot_mem[rear_idx];
          if (front_idx == rear_idx) begin
            // last word gone, indices fall back to slot 0
            deque_empty = 1'b1;
            front_idx = 0;
            rear_idx = 0;
          end else if (cmd == CMD_POP_FRONT) begin
            front_idx++;
          end else begin
            rear_idx--;
          end
          expect_reply(STAT_OK, got, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (deque_empty) begin
          expect_reply(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = front_idx; i <= rear_idx; i++) begin
            expect_reply(STAT_OK, slot_mem[i], i == rear_idx);
          end
        end
      end
      default: begin
        // undefined codes are swallowed without an answer
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [CmdW-1:0] cmd, logic signed [WordW-1:0] val);
    deque_cmd_t c;
    c.cmd = cmd;
    c.val = val;
    command_q.push_back(c);
    if (cmd <= CMD_DISPLAY) begin
      counted_cmds++;
    end
  endfunction

  // random word with the extremes mixed in
  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // stimulus: directed corner cases, then random well-formed runs with noise
  initial begin
    int unsigned n;
    queue_cmd(CMD_POP_FRONT, pick_word());
    queue_cmd(CMD_POP_BACK, pick_word());
    queue_cmd(CMD_DISPLAY, pick_word());
    queue_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    queue_cmd(CMD_PUSH_FRONT, 32'sh8000_0000);
    queue_cmd(CMD_PUSH_BACK, 32'sh8000_0000);
    queue_cmd(CMD_PUSH_BACK, -32'sd1);
    queue_cmd(CMD_PUSH_BACK, '0);
    queue_cmd(CMD_DISPLAY, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_PUSH_FRONT, 32'sh5a5a_a5a5);
    queue_cmd(CMD_POP_BACK, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_POP_BACK, -32'sd1);
    queue_cmd(CMD_PUSH_BACK, 32'sh1234_5678);
    queue_cmd(3'd5, pick_word());
    queue_cmd(3'd6, pick_word());
    queue_cmd(3'd7, -32'sd1);
    queue_cmd(CMD_DISPLAY, '0);
    queue_cmd(CMD_POP_FRONT, '0);
    queue_cmd(CMD_DISPLAY, '0);

    counted_cmds = 0;
    while (counted_cmds < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill toward the rear limit and past it
          n = $urandom_range(1, 17);
          repeat (n) queue_cmd(CMD_PUSH_BACK, pick_word());
        end
        2: begin
          n = $urandom_range(1, 6);
          repeat (n) queue_cmd(CMD_PUSH_FRONT, pick_word());
        end
        3: begin
          n = $urandom_range(1, 8);
          repeat (n) queue_cmd(CMD_POP_FRONT, pick_word());
        end
        4: begin
          n = $urandom_range(1, 8);
          repeat (n) queue_cmd(CMD_POP_BACK, pick_word());
        end
        5: queue_cmd(CMD_DISPLAY, pick_word());
        6: begin
          // drain from both ends, often down to empty
          n = $urandom_range(1, 18);
          repeat (n) queue_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                               pick_word());
        end
        7: begin
          // noise, undefined codes included
          n = $urandom_range(1, 4);
          repeat (n) queue_cmd(CmdW'($urandom_range(0, 7)), $urandom);
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) queue_cmd(CMD_PUSH_BACK, pick_word());
          queue_cmd(CMD_DISPLAY, pick_word());
        end
        default: begin
          // open room at the front, then push into it
          n = $urandom_range(1, 4);
          repeat (n) queue_cmd(CMD_POP_FRONT, pick_word());
          n = $urandom_range(1, 5);
          repeat (n) queue_cmd(CMD_PUSH_FRONT, pick_word());
          queue_cmd(CMD_DISPLAY, pick_word());
        end
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all requests taken and all answers seen
    while (command_q.size() != 0 || reply_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver: valid held until the request is taken, bursts and gaps between them
  always @(posedge clk_i) begin
    bit took;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        predict_deque(command_q[0].cmd, command_q[0].val);
        command_q.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long burst with no idling at all
          burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!in_valid_i || took) begin
        if (gap_left > 0 || command_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          command_i <= command_q[0].cmd;
          value_i <= command_q[0].val;
        end
      end
    end
  end

  // receiver stall: segments of no stall, coin-flip stall and a fixed rhythm
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_seg = $urandom_range(16, 64);
      end
      stall_seg--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= (stall_seg % 7) < 4;
      endcase
    end
  end

  // monitor: each answer against the oldest expectation
  always @(posedge clk_i) begin
    deque_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected reply, actual status %0d data %0d last %0d",
                 $realtime, status_o, data_o, last_o);
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status) begin
          fault_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $realtime, want.status, status_o);
        end
        if (data_o !== want.data) begin
          fault_count++;
          $display("%0t: data mismatch, expected %0d actual %0d",
                   $realtime, want.data, data_o);
        end
        if (last_o !== want.last) begin
          fault_count++;
          $display("%0t: last mismatch, expected %0d actual %0d",
                   $realtime, want.last, last_o);
        end
      end
    end
  end

  // watchdog: too long without any request moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
